FILE: hdl/width_limited_kahn_wavefront_scheduler_defines.svh
// Assertion macros for the wavefront scheduler.
// Used by the top level only; expects clock and reset in scope.
`ifndef WIDTH_LIMITED_KAHN_WAVEFRONT_SCHEDULER_DEFINES_SVH
`define WIDTH_LIMITED_KAHN_WAVEFRONT_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define WKWS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WKWS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/wkws_pkg.sv
// Shared types and codes of the wavefront scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wkws_pkg;

   localparam int REQ_W       = 2;
   localparam int CELL_W      = 10;
   localparam int LEVEL_W     = 10;
   localparam int DEG_W       = 8;
   localparam int FIDX_W      = 12;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_W       = 11;
   localparam int PEND_W      = 9;
   localparam int SUB_W       = 9;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 64;

   localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FETCH = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CELL    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONTRIB = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_BAD_FACE  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_ORDER     = 3'd2;
   localparam logic [STATUS_W-1:0] STS_TOO_MANY  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_DEGREE    = 3'd4;
   localparam logic [STATUS_W-1:0] STS_NOT_BUILT = 3'd5;

   localparam logic CSR_NUM_CELLS  = 1'b0;
   localparam logic CSR_WAVE_WIDTH = 1'b1;

   // pending count value marking a cell already placed in a level
   localparam logic [PEND_W-1:0] PEND_PLACED = 9'h100;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_CHK  = 11'b000_0000_0010,
      S_ZERO = 11'b000_0000_0100,
      S_CNT  = 11'b000_0000_1000,
      S_PRE  = 11'b000_0001_0000,
      S_FILL = 11'b000_0010_0000,
      S_SEL  = 11'b000_0100_0000,
      S_DEC  = 11'b000_1000_0000,
      S_DECF = 11'b001_0000_0000,
      S_FA   = 11'b010_0000_0000,
      S_FB   = 11'b100_0000_0000
   } st_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic [CELL_W-1:0]   cell_res;
      logic [LEVEL_W-1:0]  level;
      logic [DEG_W-1:0]    degree;
      logic [DEG_W-1:0]    incoming_degree;
      logic                level_last;
      logic [CELL_W-1:0]   column_cell;
      logic [FIDX_W-1:0]   face_index;
      logic                schedule_last;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hdl/width_limited_kahn_wavefront_scheduler.sv
// Width-limited Kahn wavefront scheduler, top level.
// Depends on wkws_pkg, wkws_ram and the assertion macro header.
//
//  channel   dir   handshake           content
//  req_*     in    tvalid/tready       tuser: req_type; tdata: face_owner, face_neighbour
//  rsp_*     out   tvalid/tready       tuser: kind; tdata: record fields; tlast: schedule_last
//  csr_*     in    csr_we (no wait)    csr_index selects num_cells / wave_width
//
// Load and clear items finish in the cycle they are accepted.
// A fetch is a chain of dependent reads of the cell tables, incoming face list
//   and face stores, each RAM with a registered read.
// A build walks the face store and cell tables in passes (check, zero, count,
//   prefix, list fill), then per level scans the cells and releases faces.
// Reset is synchronous; one item at a time; a waiting result blocks a new
//   item of any kind unless rsp_tready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "width_limited_kahn_wavefront_scheduler_defines.svh"
module width_limited_kahn_wavefront_scheduler #(
   parameter int MAX_CELLS    = 1024,
   parameter int MAX_FACES    = 4096,
   parameter int DEGREE_LIMIT = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // face_owner[9:0], face_neighbour[19:10], pad
   input  wire logic [1:0]  req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // status, cell_res, level, degree,
                                         // incoming_degree, level_last,
                                         // column_cell, face_index, pad
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast,   // schedule_last
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);

   localparam int CW  = $clog2(MAX_CELLS);
   localparam int NW  = $clog2(MAX_CELLS + 1);
   localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
   localparam int FCW = $clog2(MAX_FACES + 1);
   localparam int PW  = wkws_pkg::PEND_W;

   // control
   wkws_pkg::st_type st_ff, st_in;
   logic [1:0]  ph_ff, ph_in;
   logic [wkws_pkg::CSR_W-1:0] num_cells_ff, num_cells_in, wave_width_ff, wave_width_in;
   logic [FCW-1:0] fcnt_ff, fcnt_in;
   logic        ovf_ff, ovf_in, built_ff, built_in, ov_ff, ov_in;
   logic [NW-1:0] sched_ff, sched_in, pos_ff, pos_in;
   logic [wkws_pkg::SUB_W-1:0] sub_ff, sub_in;

   // build / fetch working registers
   logic [NW-1:0]  n_ff, n_in, ci_ff, ci_in, cnt_ff, cnt_in, placed_ff, placed_in, k_ff, k_in;
   logic [wkws_pkg::CSR_W-1:0] w_ff, w_in;
   logic [FCW-1:0] fi_ff, fi_in, ain_ff, ain_in, aout_ff, aout_in, ef_ff, ef_in, ee_ff, ee_in;
   logic [wkws_pkg::LEVEL_W-1:0] lvl_ff, lvl_in, flev_ff, flev_in;
   logic        bad1_ff, bad1_in, bad2_ff, bad2_in, bad4_ff, bad4_in, fin_ff, fin_in;
   logic [wkws_pkg::CELL_W-1:0] prev_ff, prev_in;
   logic [CW-1:0]  cell_ff, cell_in;
   logic [FCW-1:0] find_ff, find_in, fout_ff, fout_in, fist_ff, fist_in, fost_ff, fost_in;
   logic [FAW-1:0] fidx_ff, fidx_in;
   wkws_pkg::rsp_type res_ff, res_in;

   logic [NW-1:0] n_cl;
   logic accept;
   logic [wkws_pkg::CELL_W-1:0] f_owner, f_neigh;
   logic [wkws_pkg::SUB_W-1:0] kk, nsub;
   logic [FCW:0] deg_full;

   // RAM ports
   logic flo_we, flo_re, fhi_we, fhi_re;
   logic [FAW-1:0] flo_wa, flo_ra, fhi_wa, fhi_ra;
   logic [wkws_pkg::CELL_W-1:0] flo_wd, flo_q, fhi_wd, fhi_q;
   logic icnt_we, icnt_re, ocnt_we, ocnt_re, ist_we, ist_re, ost_we, ost_re;
   logic fill_we, fill_re, pend_we, pend_re, wave_we, wave_re, lvm_we, lvm_re;
   logic [CW-1:0] icnt_wa, icnt_ra, ocnt_wa, ocnt_ra, ist_wa, ist_ra, ost_wa, ost_ra;
   logic [CW-1:0] fill_wa, fill_ra, pend_wa, pend_ra, wave_wa, wave_ra, lvm_wa, lvm_ra;
   logic [FCW-1:0] icnt_wd, icnt_q, ocnt_wd, ocnt_q, ist_wd, ist_q, ost_wd, ost_q;
   logic [FCW-1:0] fill_wd, fill_q;
   logic [PW-1:0]  pend_wd, pend_q;
   logic [CW-1:0]  wave_wd, wave_q;
   logic [wkws_pkg::LEVEL_W-1:0] lvm_wd, lvm_q;
   logic ilist_we, ilist_re;
   logic [FAW-1:0] ilist_wa, ilist_ra, ilist_wd, ilist_q;

   // face stores, one entry per loaded face
   wkws_ram #(.WIDTH(wkws_pkg::CELL_W), .DEPTH(MAX_FACES)) u_flo (
      .clock(clock), .we(flo_we), .waddr(flo_wa), .wdata(flo_wd),
      .re(flo_re), .raddr(flo_ra), .rdata(flo_q));
   wkws_ram #(.WIDTH(wkws_pkg::CELL_W), .DEPTH(MAX_FACES)) u_fhi (
      .clock(clock), .we(fhi_we), .waddr(fhi_wa), .wdata(fhi_wd),
      .re(fhi_re), .raddr(fhi_ra), .rdata(fhi_q));
   // incoming face list, bucketed by upper cell
   wkws_ram #(.WIDTH(FAW), .DEPTH(MAX_FACES)) u_ilist (
      .clock(clock), .we(ilist_we), .waddr(ilist_wa), .wdata(ilist_wd),
      .re(ilist_re), .raddr(ilist_ra), .rdata(ilist_q));
   // per-cell tables
   wkws_ram #(.WIDTH(FCW), .DEPTH(MAX_CELLS)) u_icnt (
      .clock(clock), .we(icnt_we), .waddr(icnt_wa), .wdata(icnt_wd),
      .re(icnt_re), .raddr(icnt_ra), .rdata(icnt_q));
   wkws_ram #(.WIDTH(FCW), .DEPTH(MAX_CELLS)) u_ocnt (
      .clock(clock), .we(ocnt_we), .waddr(ocnt_wa), .wdata(ocnt_wd),
      .re(ocnt_re), .raddr(ocnt_ra), .rdata(ocnt_q));
   wkws_ram #(.WIDTH(FCW), .DEPTH(MAX_CELLS)) u_ist (
      .clock(clock), .we(ist_we), .waddr(ist_wa), .wdata(ist_wd),
      .re(ist_re), .raddr(ist_ra), .rdata(ist_q));
   wkws_ram #(.WIDTH(FCW), .DEPTH(MAX_CELLS)) u_ost (
      .clock(clock), .we(ost_we), .waddr(ost_wa), .wdata(ost_wd),
      .re(ost_re), .raddr(ost_ra), .rdata(ost_q));
   wkws_ram #(.WIDTH(FCW), .DEPTH(MAX_CELLS)) u_fill (
      .clock(clock), .we(fill_we), .waddr(fill_wa), .wdata(fill_wd),
      .re(fill_re), .raddr(fill_ra), .rdata(fill_q));
   wkws_ram #(.WIDTH(PW), .DEPTH(MAX_CELLS)) u_pend (
      .clock(clock), .we(pend_we), .waddr(pend_wa), .wdata(pend_wd),
      .re(pend_re), .raddr(pend_ra), .rdata(pend_q));
   wkws_ram #(.WIDTH(CW), .DEPTH(MAX_CELLS)) u_wave (
      .clock(clock), .we(wave_we), .waddr(wave_wa), .wdata(wave_wd),
      .re(wave_re), .raddr(wave_ra), .rdata(wave_q));
   wkws_ram #(.WIDTH(wkws_pkg::LEVEL_W), .DEPTH(MAX_CELLS)) u_lvm (
      .clock(clock), .we(lvm_we), .waddr(lvm_wa), .wdata(lvm_wd),
      .re(lvm_re), .raddr(lvm_ra), .rdata(lvm_q));

   assign req_tready = (st_ff == wkws_pkg::S_IDLE) && (!ov_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign f_owner    = req_tdata[9:0];
   assign f_neigh    = req_tdata[19:10];

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.schedule_last;
   assign rsp_tdata  = {2'b00, res_ff.face_index, res_ff.column_cell, res_ff.level_last,
                        res_ff.incoming_degree, res_ff.degree, res_ff.level,
                        res_ff.cell_res, res_ff.status};

   // register value clamped to one through the table size
   always_comb begin
      if (num_cells_ff == '0) begin
         n_cl = NW'(1);
      end else if (32'(num_cells_ff) > MAX_CELLS) begin
         n_cl = NW'(MAX_CELLS);
      end else begin
         n_cl = NW'(num_cells_ff);
      end
   end

   assign kk       = sub_ff - 1'b1;
   assign nsub     = sub_ff + 1'b1;
   assign deg_full = {1'b0, find_ff} + {1'b0, fout_ff};

   always_comb begin
      st_in = st_ff;  ph_in = ph_ff;
      num_cells_in = num_cells_ff;  wave_width_in = wave_width_ff;
      fcnt_in = fcnt_ff;  ovf_in = ovf_ff;  built_in = built_ff;  ov_in = ov_ff;
      sched_in = sched_ff;  pos_in = pos_ff;  sub_in = sub_ff;
      n_in = n_ff;  w_in = w_ff;  ci_in = ci_ff;  cnt_in = cnt_ff;  placed_in = placed_ff;
      k_in = k_ff;  fi_in = fi_ff;  ain_in = ain_ff;  aout_in = aout_ff;
      ef_in = ef_ff;  ee_in = ee_ff;  lvl_in = lvl_ff;  flev_in = flev_ff;
      bad1_in = bad1_ff;  bad2_in = bad2_ff;  bad4_in = bad4_ff;  fin_in = fin_ff;
      prev_in = prev_ff;  cell_in = cell_ff;  find_in = find_ff;  fout_in = fout_ff;
      fist_in = fist_ff;  fost_in = fost_ff;  fidx_in = fidx_ff;  res_in = res_ff;

      flo_we = 1'b0; flo_re = 1'b0; flo_wa = '0; flo_ra = '0; flo_wd = f_owner;
      fhi_we = 1'b0; fhi_re = 1'b0; fhi_wa = '0; fhi_ra = '0; fhi_wd = f_neigh;
      ilist_we = 1'b0; ilist_re = 1'b0; ilist_wa = '0; ilist_ra = '0; ilist_wd = '0;
      icnt_we = 1'b0; icnt_re = 1'b0; icnt_wa = '0; icnt_ra = '0; icnt_wd = '0;
      ocnt_we = 1'b0; ocnt_re = 1'b0; ocnt_wa = '0; ocnt_ra = '0; ocnt_wd = '0;
      ist_we = 1'b0; ist_re = 1'b0; ist_wa = '0; ist_ra = '0; ist_wd = '0;
      ost_we = 1'b0; ost_re = 1'b0; ost_wa = '0; ost_ra = '0; ost_wd = '0;
      fill_we = 1'b0; fill_re = 1'b0; fill_wa = '0; fill_ra = '0; fill_wd = '0;
      pend_we = 1'b0; pend_re = 1'b0; pend_wa = '0; pend_ra = '0; pend_wd = '0;
      wave_we = 1'b0; wave_re = 1'b0; wave_wa = '0; wave_ra = '0; wave_wd = '0;
      lvm_we = 1'b0; lvm_re = 1'b0; lvm_wa = '0; lvm_ra = '0; lvm_wd = '0;

      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      if (csr_we) begin
         if (csr_index[0] == wkws_pkg::CSR_NUM_CELLS) begin
            num_cells_in = csr_wdata;
         end else begin
            wave_width_in = csr_wdata;
         end
      end

      case (st_ff)
         wkws_pkg::S_IDLE: begin
            if (accept) begin
               res_in = '0;
               case (req_tuser)
                  wkws_pkg::REQ_LOAD: begin
                     built_in = 1'b0;
                     ov_in    = 1'b1;
                     if (!ovf_ff && (32'(fcnt_ff) < MAX_FACES)) begin
                        flo_we  = 1'b1;  flo_wa = FAW'(fcnt_ff);
                        fhi_we  = 1'b1;  fhi_wa = FAW'(fcnt_ff);
                        fcnt_in = fcnt_ff + 1'b1;
                     end else begin
                        ovf_in        = 1'b1;
                        res_in.status = wkws_pkg::STS_TOO_MANY;
                     end
                  end
                  wkws_pkg::REQ_CLEAR: begin
                     built_in = 1'b0;
                     fcnt_in  = '0;
                     ovf_in   = 1'b0;
                     ov_in    = 1'b1;
                  end
                  wkws_pkg::REQ_BUILD: begin
                     built_in = 1'b0;
                     if (ovf_ff) begin
                        ov_in         = 1'b1;
                        res_in.status = wkws_pkg::STS_TOO_MANY;
                     end else begin
                        n_in    = n_cl;
                        w_in    = (wave_width_ff == '0) ? wkws_pkg::CSR_W'(1) : wave_width_ff;
                        fi_in   = '0;
                        bad1_in = 1'b0;  bad2_in = 1'b0;  bad4_in = 1'b0;
                        st_in   = wkws_pkg::S_CHK;
                        ph_in   = 2'd0;
                     end
                  end
                  default: begin // fetch
                     if (!built_ff) begin
                        ov_in         = 1'b1;
                        res_in.status = wkws_pkg::STS_NOT_BUILT;
                     end else if (pos_ff >= sched_ff) begin
                        ov_in       = 1'b1;
                        res_in.kind = wkws_pkg::KIND_END;
                     end else begin
                        wave_re = 1'b1;
                        wave_ra = CW'(pos_ff);
                        st_in   = wkws_pkg::S_FA;
                        ph_in   = 2'd0;
                     end
                  end
               endcase
            end
         end

         // face checks: bad face over the whole list wins over owner order
         wkws_pkg::S_CHK: begin
            if (ph_ff == 2'd0) begin
               if (fi_ff == fcnt_ff) begin
                  if (bad1_ff || bad2_ff) begin
                     res_in        = '0;
                     res_in.status = bad1_ff ? wkws_pkg::STS_BAD_FACE : wkws_pkg::STS_ORDER;
                     ov_in         = 1'b1;
                     st_in         = wkws_pkg::S_IDLE;
                  end else begin
                     ci_in = '0;
                     st_in = wkws_pkg::S_ZERO;
                  end
               end else begin
                  flo_re = 1'b1;  flo_ra = FAW'(fi_ff);
                  fhi_re = 1'b1;  fhi_ra = FAW'(fi_ff);
                  ph_in  = 2'd1;
               end
            end else begin
               if ((flo_q >= fhi_q) || (32'(fhi_q) >= 32'(n_ff))) begin
                  bad1_in = 1'b1;
               end
               if ((fi_ff != '0) && (flo_q < prev_ff)) begin
                  bad2_in = 1'b1;
               end
               prev_in = flo_q;
               fi_in   = fi_ff + 1'b1;
               ph_in   = 2'd0;
            end
         end

         wkws_pkg::S_ZERO: begin
            if (ci_ff == n_ff) begin
               fi_in = '0;
               ph_in = 2'd0;
               st_in = wkws_pkg::S_CNT;
            end else begin
               icnt_we = 1'b1;  icnt_wa = CW'(ci_ff);
               ocnt_we = 1'b1;  ocnt_wa = CW'(ci_ff);
               ci_in   = ci_ff + 1'b1;
            end
         end

         // degree counting, read-modify-write one face at a time
         wkws_pkg::S_CNT: begin
            case (ph_ff)
               2'd0: begin
                  if (fi_ff == fcnt_ff) begin
                     ci_in = '0;  ain_in = '0;  aout_in = '0;
                     st_in = wkws_pkg::S_PRE;
                  end else begin
                     flo_re = 1'b1;  flo_ra = FAW'(fi_ff);
                     fhi_re = 1'b1;  fhi_ra = FAW'(fi_ff);
                     ph_in  = 2'd1;
                  end
               end
               2'd1: begin
                  icnt_re = 1'b1;  icnt_ra = CW'(fhi_q);
                  ocnt_re = 1'b1;  ocnt_ra = CW'(flo_q);
                  ph_in   = 2'd2;
               end
               default: begin
                  icnt_we = 1'b1;  icnt_wa = CW'(fhi_q);  icnt_wd = icnt_q + 1'b1;
                  ocnt_we = 1'b1;  ocnt_wa = CW'(flo_q);  ocnt_wd = ocnt_q + 1'b1;
                  fi_in   = fi_ff + 1'b1;
                  ph_in   = 2'd0;
               end
            endcase
         end

         // prefix sums, pending counts and the degree limit
         wkws_pkg::S_PRE: begin
            if (ph_ff == 2'd0) begin
               if (ci_ff == n_ff) begin
                  if (bad4_ff) begin
                     res_in        = '0;
                     res_in.status = wkws_pkg::STS_DEGREE;
                     ov_in         = 1'b1;
                     st_in         = wkws_pkg::S_IDLE;
                  end else begin
                     fi_in = '0;
                     st_in = wkws_pkg::S_FILL;
                  end
               end else begin
                  icnt_re = 1'b1;  icnt_ra = CW'(ci_ff);
                  ocnt_re = 1'b1;  ocnt_ra = CW'(ci_ff);
                  ph_in   = 2'd1;
               end
            end else begin
               ist_we  = 1'b1;  ist_wa  = CW'(ci_ff);  ist_wd  = ain_ff;
               ost_we  = 1'b1;  ost_wa  = CW'(ci_ff);  ost_wd  = aout_ff;
               fill_we = 1'b1;  fill_wa = CW'(ci_ff);  fill_wd = ain_ff;
               pend_we = 1'b1;  pend_wa = CW'(ci_ff);  pend_wd = PW'(icnt_q);
               ain_in  = ain_ff + icnt_q;
               aout_in = aout_ff + ocnt_q;
               if ((32'(icnt_q) + 32'(ocnt_q)) > DEGREE_LIMIT) begin
                  bad4_in = 1'b1;
               end
               ci_in = ci_ff + 1'b1;
               ph_in = 2'd0;
            end
         end

         // stable bucket fill of the incoming lists
         wkws_pkg::S_FILL: begin
            case (ph_ff)
               2'd0: begin
                  if (fi_ff == fcnt_ff) begin
                     placed_in = '0;  lvl_in = '0;  ci_in = '0;  cnt_in = '0;
                     st_in     = wkws_pkg::S_SEL;
                  end else begin
                     fhi_re = 1'b1;  fhi_ra = FAW'(fi_ff);
                     ph_in  = 2'd1;
                  end
               end
               2'd1: begin
                  fill_re = 1'b1;  fill_ra = CW'(fhi_q);
                  ph_in   = 2'd2;
               end
               default: begin
                  ilist_we = 1'b1;  ilist_wa = FAW'(fill_q);  ilist_wd = FAW'(fi_ff);
                  fill_we  = 1'b1;  fill_wa  = CW'(fhi_q);    fill_wd  = fill_q + 1'b1;
                  fi_in    = fi_ff + 1'b1;
                  ph_in    = 2'd0;
               end
            endcase
         end

         // level selection: lowest ready cells first, up to the wave width
         wkws_pkg::S_SEL: begin
            if (ph_ff == 2'd0) begin
               if ((placed_ff == n_ff) ||
                   (((ci_ff == n_ff) || (32'(cnt_ff) == 32'(w_ff))) && (cnt_ff == '0))) begin
                  res_in    = '0;
                  ov_in     = 1'b1;
                  built_in  = 1'b1;
                  sched_in  = placed_ff;
                  pos_in    = '0;
                  sub_in    = '0;
                  st_in     = wkws_pkg::S_IDLE;
               end else if ((ci_ff == n_ff) || (32'(cnt_ff) == 32'(w_ff))) begin
                  k_in  = '0;
                  st_in = wkws_pkg::S_DEC;
               end else begin
                  pend_re = 1'b1;  pend_ra = CW'(ci_ff);
                  ph_in   = 2'd1;
               end
            end else begin
               if (pend_q == '0) begin
                  pend_we = 1'b1;  pend_wa = CW'(ci_ff);  pend_wd = wkws_pkg::PEND_PLACED;
                  wave_we = 1'b1;  wave_wa = CW'(placed_ff + cnt_ff);  wave_wd = CW'(ci_ff);
                  lvm_we  = 1'b1;  lvm_wa  = CW'(ci_ff);  lvm_wd  = lvl_ff;
                  cnt_in  = cnt_ff + 1'b1;
               end
               ci_in = ci_ff + 1'b1;
               ph_in = 2'd0;
            end
         end

         // release successors of the cells of the level just formed
         wkws_pkg::S_DEC: begin
            case (ph_ff)
               2'd0: begin
                  if (k_ff == cnt_ff) begin
                     placed_in = placed_ff + cnt_ff;
                     lvl_in    = lvl_ff + 1'b1;
                     ci_in     = '0;
                     cnt_in    = '0;
                     st_in     = wkws_pkg::S_SEL;
                  end else begin
                     wave_re = 1'b1;  wave_ra = CW'(placed_ff + k_ff);
                     ph_in   = 2'd1;
                  end
               end
               2'd1: begin
                  ost_re  = 1'b1;  ost_ra  = wave_q;
                  ocnt_re = 1'b1;  ocnt_ra = wave_q;
                  ph_in   = 2'd2;
               end
               default: begin
                  ef_in = ost_q;
                  ee_in = ost_q + ocnt_q;
                  ph_in = 2'd0;
                  st_in = wkws_pkg::S_DECF;
               end
            endcase
         end

         wkws_pkg::S_DECF: begin
            case (ph_ff)
               2'd0: begin
                  if (ef_ff == ee_ff) begin
                     k_in  = k_ff + 1'b1;
                     st_in = wkws_pkg::S_DEC;
                  end else begin
                     fhi_re = 1'b1;  fhi_ra = FAW'(ef_ff);
                     ph_in  = 2'd1;
                  end
               end
               2'd1: begin
                  pend_re = 1'b1;  pend_ra = CW'(fhi_q);
                  ph_in   = 2'd2;
               end
               default: begin
                  pend_we = 1'b1;  pend_wa = CW'(fhi_q);  pend_wd = pend_q - 1'b1;
                  ef_in   = ef_ff + 1'b1;
                  ph_in   = 2'd0;
               end
            endcase
         end

         // fetch: cell lookup, next cell's level, then the face
         wkws_pkg::S_FA: begin
            case (ph_ff)
               2'd0: begin
                  cell_in = wave_q;
                  lvm_re  = 1'b1;  lvm_ra  = wave_q;
                  icnt_re = 1'b1;  icnt_ra = wave_q;
                  ocnt_re = 1'b1;  ocnt_ra = wave_q;
                  ist_re  = 1'b1;  ist_ra  = wave_q;
                  ost_re  = 1'b1;  ost_ra  = wave_q;
                  wave_re = 1'b1;  wave_ra = CW'(pos_ff + 1'b1);
                  ph_in   = 2'd1;
               end
               2'd1: begin
                  flev_in = lvm_q;
                  find_in = icnt_q;
                  fout_in = ocnt_q;
                  fist_in = ist_q;
                  fost_in = ost_q;
                  lvm_re  = 1'b1;  lvm_ra = wave_q;
                  ph_in   = 2'd2;
               end
               default: begin
                  if (sub_ff == '0) begin
                     res_in                 = '0;
                     res_in.kind            = wkws_pkg::KIND_CELL;
                     res_in.cell_res        = wkws_pkg::CELL_W'(cell_ff);
                     res_in.level           = flev_ff;
                     res_in.degree          = wkws_pkg::DEG_W'(deg_full);
                     res_in.incoming_degree = wkws_pkg::DEG_W'(find_ff);
                     res_in.level_last      = ((32'(pos_ff) + 1) >= 32'(sched_ff)) ||
                                              (lvm_q != flev_ff);
                     if (32'(nsub) > 32'(deg_full)) begin
                        sub_in = '0;
                        pos_in = pos_ff + 1'b1;
                        res_in.schedule_last = ((32'(pos_ff) + 1) >= 32'(sched_ff));
                     end else begin
                        sub_in = nsub;
                     end
                     ov_in = 1'b1;
                     st_in = wkws_pkg::S_IDLE;
                  end else if (32'(kk) < 32'(find_ff)) begin
                     ilist_re = 1'b1;
                     ilist_ra = FAW'(32'(fist_ff) + 32'(kk));
                     fin_in   = 1'b1;
                     ph_in    = 2'd0;
                     st_in    = wkws_pkg::S_FB;
                  end else begin
                     fidx_in = FAW'(32'(fost_ff) + 32'(kk) - 32'(find_ff));
                     fhi_re  = 1'b1;
                     fhi_ra  = FAW'(32'(fost_ff) + 32'(kk) - 32'(find_ff));
                     fin_in  = 1'b0;
                     ph_in   = 2'd0;
                     st_in   = wkws_pkg::S_FB;
                  end
               end
            endcase
         end

         wkws_pkg::S_FB: begin
            if ((ph_ff == 2'd0) && fin_ff) begin
               fidx_in = ilist_q;
               flo_re  = 1'b1;  flo_ra = ilist_q;
               ph_in   = 2'd1;
            end else begin
               res_in                 = '0;
               res_in.kind            = wkws_pkg::KIND_CONTRIB;
               res_in.cell_res        = wkws_pkg::CELL_W'(cell_ff);
               res_in.level           = flev_ff;
               res_in.degree          = wkws_pkg::DEG_W'(deg_full);
               res_in.incoming_degree = wkws_pkg::DEG_W'(find_ff);
               res_in.column_cell     = fin_ff ? flo_q : fhi_q;
               res_in.face_index      = wkws_pkg::FIDX_W'(fidx_ff);
               if (32'(nsub) > 32'(deg_full)) begin
                  sub_in = '0;
                  pos_in = pos_ff + 1'b1;
                  res_in.schedule_last = ((32'(pos_ff) + 1) >= 32'(sched_ff));
               end else begin
                  sub_in = nsub;
               end
               ov_in = 1'b1;
               ph_in = 2'd0;
               st_in = wkws_pkg::S_IDLE;
            end
         end

         default: begin
            st_in = wkws_pkg::S_IDLE;
            ph_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= wkws_pkg::S_IDLE;
         ph_ff         <= 2'd0;
         num_cells_ff  <= wkws_pkg::CSR_W'(1);
         wave_width_ff <= wkws_pkg::CSR_W'(1);
         fcnt_ff       <= '0;
         ovf_ff        <= 1'b0;
         built_ff      <= 1'b0;
         ov_ff         <= 1'b0;
         sched_ff      <= '0;
         pos_ff        <= '0;
         sub_ff        <= '0;
      end else begin
         st_ff         <= st_in;
         ph_ff         <= ph_in;
         num_cells_ff  <= num_cells_in;
         wave_width_ff <= wave_width_in;
         fcnt_ff       <= fcnt_in;
         ovf_ff        <= ovf_in;
         built_ff      <= built_in;
         ov_ff         <= ov_in;
         sched_ff      <= sched_in;
         pos_ff        <= pos_in;
         sub_ff        <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;  w_ff <= w_in;  ci_ff <= ci_in;  cnt_ff <= cnt_in;
      placed_ff <= placed_in;  k_ff <= k_in;  fi_ff <= fi_in;
      ain_ff <= ain_in;  aout_ff <= aout_in;  ef_ff <= ef_in;  ee_ff <= ee_in;
      lvl_ff <= lvl_in;  flev_ff <= flev_in;
      bad1_ff <= bad1_in;  bad2_ff <= bad2_in;  bad4_ff <= bad4_in;  fin_ff <= fin_in;
      prev_ff <= prev_in;  cell_ff <= cell_in;  find_ff <= find_in;  fout_ff <= fout_in;
      fist_ff <= fist_in;  fost_ff <= fost_in;  fidx_ff <= fidx_in;  res_ff <= res_in;
   end

   // records only come out of a built schedule
   `WKWS_ASSERT_NOW(a_rec_built, rsp_tvalid && (res_ff.kind == wkws_pkg::KIND_CELL || res_ff.kind == wkws_pkg::KIND_CONTRIB), built_ff, "record without a built schedule")

   // fetch cursor never passes the scheduled cell count
   `WKWS_ASSERT_NOW(a_pos_range, built_ff, pos_ff <= sched_ff, "fetch cursor beyond schedule")

   // an acyclic face list always yields a ready cell until all are placed
   `WKWS_ASSERT_NOW(a_sel_progress, st_ff == wkws_pkg::S_SEL && ph_ff == 2'd0 && ci_ff == n_ff && cnt_ff == '0, placed_ff == n_ff, "empty level before all cells placed")

   // a released successor is still waiting on at least one predecessor
   `WKWS_ASSERT_NOW(a_dec_target, st_ff == wkws_pkg::S_DECF && ph_ff == 2'd2, pend_q != '0 && pend_q != wkws_pkg::PEND_PLACED, "decrement of a placed or free cell")

endmodule
`default_nettype wire

FILE: hdl/wkws_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wkws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: sim/width_limited_kahn_wavefront_scheduler_tb.sv
// Self-checking testbench for the width-limited Kahn wavefront scheduler.
// Needs wkws_pkg and the scheduler top level; drives directed rows, then fixed edge cases and random graphs.
`timescale 1ns / 1ps
module width_limited_kahn_wavefront_scheduler_tb;
   import wkws_pkg::*;

   localparam int N_CELLS = 1024;
   localparam int N_FACES = 4096;
   localparam int DEG_MAX = 255;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;

   width_limited_kahn_wavefront_scheduler u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Schedule predictor: own copy of face stores, tables and cursor
   // ---------------------------------------------------------------
   int unsigned cfg_cells = 1, cfg_width = 1;
   int unsigned face_lo [N_FACES];
   int unsigned face_hi [N_FACES];
   int unsigned face_cnt = 0;
   int unsigned in_base  [N_CELLS+1];
   int unsigned out_base [N_CELLS+1];
   int unsigned in_list  [N_FACES];
   int unsigned lvl_of   [N_CELLS];
   int unsigned order    [N_CELLS];
   bit          is_built = 0;
   int unsigned placed_cells = 0, cur_pos = 0, cur_sub = 0;

   function automatic logic [STATUS_W-1:0] build_schedule();
      int unsigned n, w, placed, lvl, cnt, h;
      int unsigned pend [N_CELLS];
      int unsigned fill [N_CELLS];
      bit          rdy  [N_CELLS];
      n = cfg_cells;
      w = cfg_width;
      if (n < 1) n = 1;
      if (n > N_CELLS) n = N_CELLS;
      if (w < 1) w = 1;
      is_built = 0;
      if (face_cnt > N_FACES) return STS_TOO_MANY;
      for (int f = 0; f < face_cnt; f++)
         if (face_lo[f] >= face_hi[f] || face_hi[f] >= n) return STS_BAD_FACE;
      for (int f = 1; f < face_cnt; f++)
         if (face_lo[f] < face_lo[f-1]) return STS_ORDER;
      for (int c = 0; c <= N_CELLS; c++) begin
         in_base[c] = 0;
         out_base[c] = 0;
      end
      for (int c = 0; c < N_CELLS; c++) pend[c] = 0;
      for (int f = 0; f < face_cnt; f++) begin
         in_base[face_hi[f]+1]++;
         out_base[face_lo[f]+1]++;
         pend[face_hi[f]]++;
      end
      for (int c = 0; c < n; c++) begin
         in_base[c+1] += in_base[c];
         out_base[c+1] += out_base[c];
      end
      for (int c = 0; c < n; c++)
         if (in_base[c+1] - in_base[c] + out_base[c+1] - out_base[c] > DEG_MAX)
            return STS_DEGREE;
      // stable bucket fill of the incoming lists
      for (int c = 0; c < n; c++) fill[c] = in_base[c];
      for (int f = 0; f < face_cnt; f++) begin
         in_list[fill[face_hi[f]]] = f;
         fill[face_hi[f]]++;
      end
      for (int c = 0; c < N_CELLS; c++) rdy[c] = (c < n) && (pend[c] == 0);
      placed = 0;
      lvl = 0;
      while (placed < n) begin
         cnt = 0;
         for (int c = 0; c < n && cnt < w; c++)
            if (rdy[c]) begin
               rdy[c] = 0;
               order[placed+cnt] = c;
               lvl_of[c] = lvl;
               cnt++;
            end
         if (cnt == 0) break;
         // cells released here only become ready for the next level
         for (int k = 0; k < cnt; k++)
            for (int f = out_base[order[placed+k]]; f < out_base[order[placed+k]+1]; f++) begin
               h = face_hi[f];
               pend[h]--;
               if (pend[h] == 0) rdy[h] = 1;
            end
         placed += cnt;
         lvl++;
      end
      is_built = 1;
      placed_cells = placed;
      cur_pos = 0;
      cur_sub = 0;
      return STS_OK;
   endfunction

   function automatic rsp_type predict_record(logic [1:0] op, int unsigned own, int unsigned nbr);
      rsp_type     r;
      int unsigned c, ind, deg, k, f;
      r = '0;
      case (op)
         REQ_LOAD: begin
            is_built = 0;
            if (face_cnt < N_FACES) begin
               face_lo[face_cnt] = own;
               face_hi[face_cnt] = nbr;
               face_cnt++;
            end else begin
               face_cnt = N_FACES + 1;
               r.status = STS_TOO_MANY;
            end
         end
         REQ_BUILD: r.status = build_schedule();
         REQ_CLEAR: begin
            is_built = 0;
            face_cnt = 0;
         end
         default: begin
            if (!is_built) r.status = STS_NOT_BUILT;
            else if (cur_pos >= placed_cells) r.kind = KIND_END;
            else begin
               c = order[cur_pos];
               ind = in_base[c+1] - in_base[c];
               deg = ind + out_base[c+1] - out_base[c];
               r.cell_res = c;
               r.level = lvl_of[c];
               r.degree = deg;
               r.incoming_degree = ind;
               if (cur_sub == 0) begin
                  r.kind = KIND_CELL;
                  r.level_last = (cur_pos + 1 >= placed_cells) ||
                                 (lvl_of[order[cur_pos+1]] != lvl_of[c]);
               end else begin
                  k = cur_sub - 1;
                  r.kind = KIND_CONTRIB;
                  if (k < ind) begin
                     f = in_list[in_base[c] + k];
                     r.column_cell = face_lo[f];
                  end else begin
                     f = out_base[c] + k - ind;
                     r.column_cell = face_hi[f];
                  end
                  r.face_index = f;
               end
               cur_sub++;
               if (cur_sub > deg) begin
                  cur_sub = 0;
                  cur_pos++;
               end
               r.schedule_last = (cur_pos >= placed_cells);
            end
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   rsp_type     pending_records[$];
   int unsigned items_sent = 0;
   int unsigned mismatches = 0;

   // Drive one item; the predicted record goes into the queue unless a
   // typed-in record is given. valid stays high after the handshake so the
   // caller must act in the same time step.
   task automatic send_item(logic [1:0] op, int unsigned own, int unsigned nbr,
                            bit typed = 0, rsp_type typed_rec = '0);
      int unsigned gap;
      rsp_type     pred;
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pred = predict_record(op, own, nbr);
      pending_records.push_back(typed ? typed_rec : pred);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, nbr[9:0], own[9:0]};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Registers move only with the block idle and nothing outstanding.
   task automatic write_csr(logic idx, int unsigned value);
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[10:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NUM_CELLS) cfg_cells = value & 11'h7FF;
      else cfg_width = value & 11'h7FF;
   endtask

   // ---------------------------------------------------------------
   // Result side: random stalls, field-by-field compare
   // ---------------------------------------------------------------
   function automatic int unsigned field_of(rsp_type r, int idx);
      case (idx)
         0: return r.kind;
         1: return r.status;
         2: return r.cell_res;
         3: return r.level;
         4: return r.degree;
         5: return r.incoming_degree;
         6: return r.level_last;
         7: return r.column_cell;
         8: return r.face_index;
         default: return r.schedule_last;
      endcase
   endfunction

   string field_name[10] = '{"kind", "status", "cell_res", "level", "degree",
                             "incoming_degree", "level_last", "column_cell",
                             "face_index", "schedule_last"};

   initial begin : result_side
      int unsigned gap;
      rsp_type     got, want;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         // tdata: status, cell_res, level, degree, incoming_degree, level_last,
         //        column_cell, face_index from bit 0 up
         got.kind            = rsp_tuser;
         got.status          = rsp_tdata[2:0];
         got.cell_res        = rsp_tdata[12:3];
         got.level           = rsp_tdata[22:13];
         got.degree          = rsp_tdata[30:23];
         got.incoming_degree = rsp_tdata[38:31];
         got.level_last      = rsp_tdata[39];
         got.column_cell     = rsp_tdata[49:40];
         got.face_index      = rsp_tdata[61:50];
         got.schedule_last   = rsp_tlast;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected item kind %0d tdata %h", $time, got.kind, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_records.pop_front();
            for (int i = 0; i < 10; i++)
               if (field_of(got, i) != field_of(want, i)) begin
                  $display("%0t: %s expected %0d actual %0d", $time, field_name[i],
                           field_of(want, i), field_of(got, i));
                  mismatches++;
               end
         end
      end
   end

   // ---------------------------------------------------------------
   // Directed rows
   // ---------------------------------------------------------------
   typedef struct {
      bit          is_csr;   // register write instead of an item
      logic [1:0]  op;       // request code, or register index
      int unsigned a, b;     // owner/neighbour, or value in a
      bit          typed;    // record below is typed in
      logic [1:0]  kind;
      logic [2:0]  status;
   } row_t;

   row_t rows[] = '{
      '{0, REQ_FETCH, 0,    0,    1, KIND_STATUS, STS_NOT_BUILT},
      '{0, REQ_BUILD, 0,    0,    1, KIND_STATUS, STS_OK},
      '{0, REQ_FETCH, 0,    0,    0, KIND_STATUS, STS_OK},
      '{0, REQ_FETCH, 0,    0,    1, KIND_END,    STS_OK},
      '{0, REQ_FETCH, 0,    0,    1, KIND_END,    STS_OK},
      '{0, REQ_LOAD,  0,    1023, 1, KIND_STATUS, STS_OK},
      '{0, REQ_BUILD, 0,    0,    1, KIND_STATUS, STS_BAD_FACE},
      '{0, REQ_FETCH, 0,    0,    1, KIND_STATUS, STS_NOT_BUILT},
      '{0, REQ_CLEAR, 1023, 1023, 1, KIND_STATUS, STS_OK},
      '{1, CSR_NUM_CELLS,  8, 0,  0, KIND_STATUS, STS_OK},
      '{1, CSR_WAVE_WIDTH, 2, 0,  0, KIND_STATUS, STS_OK},
      '{0, REQ_LOAD,  3,    7,    1, KIND_STATUS, STS_OK},
      '{0, REQ_LOAD,  1,    7,    1, KIND_STATUS, STS_OK},
      '{0, REQ_BUILD, 0,    0,    1, KIND_STATUS, STS_ORDER},
      '{0, REQ_CLEAR, 0,    0,    1, KIND_STATUS, STS_OK},
      '{0, REQ_LOAD,  5,    4,    1, KIND_STATUS, STS_OK},
      '{0, REQ_BUILD, 0,    0,    1, KIND_STATUS, STS_BAD_FACE},
      '{0, REQ_CLEAR, 0,    0,    1, KIND_STATUS, STS_OK},
      '{0, REQ_LOAD,  0,    1,    1, KIND_STATUS, STS_OK},
      '{0, REQ_LOAD,  0,    2,    1, KIND_STATUS, STS_OK},
      '{0, REQ_LOAD,  1,    3,    1, KIND_STATUS, STS_OK},
      '{0, REQ_LOAD,  3,    7,    1, KIND_STATUS, STS_OK},
      '{0, REQ_BUILD, 0,    0,    1, KIND_STATUS, STS_OK},
      '{0, REQ_FETCH, 0,    0,    0, KIND_STATUS, STS_OK},
      '{0, REQ_FETCH, 0,    0,    0, KIND_STATUS, STS_OK},
      '{0, REQ_FETCH, 0,    0,    0, KIND_STATUS, STS_OK},
      '{0, REQ_FETCH, 0,    0,    0, KIND_STATUS, STS_OK},
      '{0, REQ_FETCH, 0,    0,    0, KIND_STATUS, STS_OK}
   };

   // One random phase: registers, a clear, a lower-first graph (sometimes broken)
   // loaded with occasional noise items, a build and a walk through the records.
   task automatic run_graph(int unsigned nc, int unsigned ww, int unsigned max_faces);
      int unsigned n_eff, nf, hit, records;
      int unsigned owners[$];
      int unsigned nbrs[$];
      write_csr(CSR_NUM_CELLS, nc);
      write_csr(CSR_WAVE_WIDTH, ww);
      n_eff = (nc < 1) ? 1 : (nc > N_CELLS) ? N_CELLS : nc;
      send_item(REQ_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
      nf = (n_eff < 2) ? 0 : $urandom_range(0, max_faces);
      for (int i = 0; i < nf; i++) owners.push_back($urandom_range(0, n_eff - 2));
      owners.sort();
      foreach (owners[i]) nbrs.push_back($urandom_range(owners[i] + 1, n_eff - 1));
      if (nf > 0 && $urandom_range(0, 99) < 15) begin
         hit = $urandom_range(0, nf - 1);
         case ($urandom_range(0, 2))
            0: owners[hit] = nbrs[hit];
            1: nbrs[hit] = $urandom_range(0, 1023);
            default: owners[hit] = $urandom_range(0, 1023);
         endcase
      end
      foreach (owners[i]) begin
         // occasional noise item in the middle of a load
         if ($urandom_range(0, 99) < 3)
            send_item($urandom_range(0, 3), $urandom_range(0, 1023), $urandom_range(0, 1023));
         send_item(REQ_LOAD, owners[i], nbrs[i]);
      end
      send_item(REQ_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
      records = is_built ? n_eff + 2 * face_cnt : 2;
      if ($urandom_range(0, 3) == 0) records = $urandom_range(0, records);
      else records = records + $urandom_range(0, 2);
      repeat (records)
         send_item(REQ_FETCH, $urandom_range(0, 1023), $urandom_range(0, 1023));
   endtask

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin : stimulus
      int unsigned nc, ww, items_goal;
      rsp_type     rec;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].is_csr) write_csr(rows[i].op[0], rows[i].a);
         else begin
            rec = '0;
            rec.kind = rows[i].kind;
            rec.status = rows[i].status;
            send_item(rows[i].op, rows[i].a, rows[i].b, rows[i].typed, rec);
         end
      end

      // register extremes: out-of-range values, full cell count, one wide level
      run_graph(0, 0, 0);
      run_graph(2047, 2047, 20);
      run_graph(1024, 1024, 30);
      run_graph(3, 0, 3);

      // degree at the limit gives full 8-bit degrees, one more fails the build
      write_csr(CSR_NUM_CELLS, 2);
      send_item(REQ_CLEAR, 0, 0);
      repeat (DEG_MAX) send_item(REQ_LOAD, 0, 1);
      send_item(REQ_BUILD, 0, 0);
      repeat (12) send_item(REQ_FETCH, 0, 0);
      send_item(REQ_LOAD, 0, 1);
      send_item(REQ_BUILD, 0, 0);

      // full face store: bipartite graph, fetch up to the high face numbers,
      // then one load too many and the overflow status sticks until a clear
      write_csr(CSR_NUM_CELLS, 1024);
      write_csr(CSR_WAVE_WIDTH, 1024);
      send_item(REQ_CLEAR, 0, 0);
      for (int f = 0; f < N_FACES; f++) send_item(REQ_LOAD, f / 8, 512 + f % 512);
      send_item(REQ_BUILD, 0, 0);
      repeat (512 * 9 + 30) send_item(REQ_FETCH, 0, 0);
      send_item(REQ_LOAD, 1, 2);
      send_item(REQ_BUILD, 0, 0);
      send_item(REQ_FETCH, 0, 0);
      send_item(REQ_CLEAR, 0, 0);
      send_item(REQ_BUILD, 0, 0);

      // random graphs, mostly small
      items_goal = items_sent + 800;
      while (items_sent < items_goal) begin
         case ($urandom_range(0, 9))
            0: nc = $urandom_range(0, 2047);
            1: nc = $urandom_range(1, 3);
            default: nc = $urandom_range(2, 24);
         endcase
         case ($urandom_range(0, 5))
            0: ww = 0;
            1: ww = $urandom_range(0, 2047);
            default: ww = $urandom_range(1, 6);
         endcase
         run_graph(nc, ww, (nc > 64) ? 12 : 40);
      end

      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/wkws_pkg.sv
hdl/wkws_ram.sv
hdl/width_limited_kahn_wavefront_scheduler.sv
sim/width_limited_kahn_wavefront_scheduler_tb.sv
